// ===== rtl/ipv4dq_pkg.sv =====
package ipv4dq_pkg;

	localparam int CHAR_W    = 8;
	localparam int OCTET_W   = 9;
	localparam int DOT_W     = 3;
	localparam int DIG_W     = 2;
	localparam int POS_W     = 4;
	localparam int MIN_CHARS = 7;

	localparam logic [CHAR_W-1:0]  CH_DOT      = 8'h2e;
	localparam logic [CHAR_W-1:0]  CH_ZERO     = 8'h30;
	localparam logic [CHAR_W-1:0]  CH_NINE     = 8'h39;
	localparam logic [OCTET_W-1:0] OCTET_MAX   = 9'd255;
	localparam logic [OCTET_W-1:0] OCTET_SAT   = 9'd256;
	localparam logic [DOT_W-1:0]   NEEDED_DOTS = 3'd3;
	localparam logic [DIG_W-1:0]   DIG_SAT     = 2'd3;
	localparam logic [POS_W-1:0]   NAME_LEN    = 4'd9;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last_char;
	} word_t;

	typedef struct packed {
		logic address_ok;
		logic matched_localhost;
	} verdict_t;

	function automatic logic [CHAR_W-1:0] name_char(input logic [POS_W-1:0] pos);
		logic [CHAR_W-1:0] c;
		unique case (pos)
			4'd0: c = 8'h6c;
			4'd1: c = 8'h6f;
			4'd2: c = 8'h63;
			4'd3: c = 8'h61;
			4'd4: c = 8'h6c;
			4'd5: c = 8'h68;
			4'd6: c = 8'h6f;
			4'd7: c = 8'h73;
			4'd8: c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/ipv4_dotted_quad_checker_unit.sv =====
// channel  handshake             payload
// input    in_valid / in_ready   char_code[7:0], last_char
// output   out_valid / out_ready address_ok, matched_localhost
//
// One character is taken per cycle while in_ready is high; each passes an
// input register and a combinational scan update, and the verdict is then
// registered in the output stage. Scan state is cleared by reset and after
// each verdict. A held verdict stalls a following last character and the
// input behind it; other characters keep flowing through the scan.
module ipv4_dotted_quad_checker_unit #(
	parameter int MAX_CHARS = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       address_ok,
	output logic       matched_localhost
);
	import ipv4dq_pkg::*;

	localparam int LEN_W = $clog2(MAX_CHARS + 2);

	word_t    in_word;
	word_t    word_s1;
	logic     valid_s1;
	logic     advance;
	logic     out_free;
	logic     busy;
	verdict_t verdict;
	verdict_t verdict_s2;

	assign in_word = {char_code, last_char};
	assign advance = valid_s1 && (!word_s1.last_char || out_free);

	ipv4dq_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	ipv4dq_scan #(
		.MAX_CHARS (MAX_CHARS),
		.LEN_W     (LEN_W)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.word    (word_s1),
		.verdict (verdict),
		.busy    (busy)
	);

	ipv4dq_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && word_s1.last_char),
		.verdict    (verdict),
		.free       (out_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.verdict_s2 (verdict_s2)
	);

	assign address_ok        = verdict_s2.address_ok;
	assign matched_localhost = verdict_s2.matched_localhost;

	a_name_implies_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!matched_localhost || address_ok))
		else $error("localhost verdict without address_ok");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && word_s1.last_char) |=> !busy)
		else $error("scan state not cleared after verdict");

	a_count_mid_word: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !word_s1.last_char) |=> busy)
		else $error("scan state lost mid-string");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && word_s1.last_char && out_valid && !out_ready))
		else $error("input stalled without a held verdict");

endmodule

// ===== rtl/ipv4dq_in_stage.sv =====
module ipv4dq_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ipv4dq_pkg::word_t   in_word,
	input  logic                advance,
	output logic                valid_s1,
	output ipv4dq_pkg::word_t   word_s1
);
	import ipv4dq_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

endmodule

// ===== rtl/ipv4dq_scan.sv =====
module ipv4dq_scan #(
	parameter int MAX_CHARS = 15,
	parameter int LEN_W     = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  ipv4dq_pkg::word_t     word,
	output ipv4dq_pkg::verdict_t  verdict,
	output logic                  busy
);
	import ipv4dq_pkg::*;

	logic [LEN_W-1:0]   len_q, len_n;
	logic [DOT_W-1:0]   dot_q, dot_n;
	logic [OCTET_W-1:0] val_q, val_n;
	logic [DIG_W-1:0]   dig_q, dig_n;
	logic               lz_q, lz_n;
	logic               err_q, err_n;
	logic [POS_W-1:0]   pos_q, pos_n;
	logic               mism_q, mism_n;

	always_comb begin
		logic [11:0]       prod;
		logic [CHAR_W-1:0] ch;
		logic              err_f;
		logic              named;
		logic              ok;

		ch    = word.char_code;
		len_n = len_q;
		dot_n = dot_q;
		val_n = val_q;
		dig_n = dig_q;
		lz_n  = lz_q;
		err_n = err_q;
		pos_n = pos_q;
		mism_n = mism_q;
		prod  = (12'(val_q) << 3) + (12'(val_q) << 1) + 12'(ch[3:0]);

		if (len_q <= LEN_W'(MAX_CHARS)) begin
			len_n = LEN_W'(len_q + 1'b1);
		end

		if (!mism_q) begin
			if (pos_q < NAME_LEN && ch == name_char(pos_q)) begin
				pos_n = POS_W'(pos_q + 1'b1);
			end else begin
				mism_n = 1'b1;
			end
		end

		priority if (ch == CH_DOT) begin
			if (dig_q == '0 || val_q > OCTET_MAX || (lz_q && dig_q >= 2'd2)) begin
				err_n = 1'b1;
			end
			val_n = '0;
			dig_n = '0;
			lz_n  = 1'b0;
			if (dot_q <= NEEDED_DOTS) begin
				dot_n = DOT_W'(dot_q + 1'b1);
			end
		end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
			if (dig_q == '0 && ch == CH_ZERO) begin
				lz_n = 1'b1;
			end
			val_n = (prod > 12'(OCTET_SAT)) ? OCTET_SAT : prod[OCTET_W-1:0];
			if (dig_q < DIG_SAT) begin
				dig_n = DIG_W'(dig_q + 1'b1);
			end
		end else begin
			err_n = 1'b1;
		end

		err_f = err_n || dig_n == '0 || val_n > OCTET_MAX || (lz_n && dig_n >= 2'd2);
		named = !mism_n && pos_n == NAME_LEN;
		ok    = !err_f && dot_n == NEEDED_DOTS &&
		        len_n >= LEN_W'(MIN_CHARS) && len_n <= LEN_W'(MAX_CHARS);
		verdict.address_ok        = named || ok;
		verdict.matched_localhost = named;
	end

	assign busy = len_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			dot_q  <= '0;
			val_q  <= '0;
			dig_q  <= '0;
			lz_q   <= 1'b0;
			err_q  <= 1'b0;
			pos_q  <= '0;
			mism_q <= 1'b0;
		end else if (step) begin
			if (word.last_char) begin
				len_q  <= '0;
				dot_q  <= '0;
				val_q  <= '0;
				dig_q  <= '0;
				lz_q   <= 1'b0;
				err_q  <= 1'b0;
				pos_q  <= '0;
				mism_q <= 1'b0;
			end else begin
				len_q  <= len_n;
				dot_q  <= dot_n;
				val_q  <= val_n;
				dig_q  <= dig_n;
				lz_q   <= lz_n;
				err_q  <= err_n;
				pos_q  <= pos_n;
				mism_q <= mism_n;
			end
		end
	end

endmodule

// ===== rtl/ipv4dq_out_stage.sv =====
module ipv4dq_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  ipv4dq_pkg::verdict_t  verdict,
	output logic                  free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ipv4dq_pkg::verdict_t  verdict_s2
);
	import ipv4dq_pkg::*;

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			verdict_s2 <= verdict;
		end
	end

endmodule

// ===== dv/tb_ipv4_dotted_quad_checker_unit.sv =====
`timescale 1ns / 1ps
module tb_ipv4_dotted_quad_checker_unit;
	import ipv4dq_pkg::*;

	localparam int MAX_LEN = 15;
	localparam int RUN_ITEMS = 1600;
	localparam int CYCLE_LIMIT = 500000;
	localparam int BUF_LEN = 64;
	localparam logic [8*9-1:0] HOST_NAME = "localhost";

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] char_code = 8'h00;
	logic last_char = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic address_ok;
	logic matched_localhost;

	ipv4_dotted_quad_checker_unit #(
		.MAX_CHARS(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.address_ok(address_ok),
		.matched_localhost(matched_localhost)
	);

	always #5 clk = ~clk;

	logic [4:0] len_cnt;
	logic [2:0] dot_cnt;
	logic [8:0] oct_val;
	logic [1:0] oct_digs;
	logic       oct_lz;
	logic       fmt_err;
	logic [3:0] name_pos;
	logic       name_off;

	verdict_t verdict_q[$];
	verdict_t want_v;
	verdict_t got_v;

	int err_count = 0;
	int chars_sent = 0;
	int strings_sent = 0;
	int verdicts_seen = 0;
	int ok_seen = 0;
	int host_seen = 0;
	int cycle_count = 0;
	int stall_left = 0;
	bit quiet_in = 1'b0;
	bit quiet_out = 1'b0;

	logic [7:0] str_buf [0:BUF_LEN-1];
	int str_len = 0;

	function automatic logic [7:0] host_byte(input int i);
		return HOST_NAME[8*(8-i) +: 8];
	endfunction

	function automatic void clear_octet();
		oct_val = '0;
		oct_digs = '0;
		oct_lz = 1'b0;
	endfunction

	function automatic void end_octet();
		if (oct_digs == 0 || oct_val > OCTET_MAX || (oct_lz && oct_digs >= 2))
			fmt_err = 1'b1;
		clear_octet();
	endfunction

	function automatic void clear_scan();
		len_cnt = '0;
		dot_cnt = '0;
		clear_octet();
		fmt_err = 1'b0;
		name_pos = '0;
		name_off = 1'b0;
	endfunction

	function automatic bit scan_char(input logic [7:0] c, input logic fin, output verdict_t v);
		int acc;
		bit named;
		bit good;
		v = '0;
		if (len_cnt <= MAX_LEN)
			len_cnt = len_cnt + 1'b1;
		if (!name_off) begin
			if (name_pos < NAME_LEN && c == host_byte(name_pos))
				name_pos = name_pos + 1'b1;
			else
				name_off = 1'b1;
		end
		if (c == CH_DOT) begin
			end_octet();
			if (dot_cnt <= NEEDED_DOTS)
				dot_cnt = dot_cnt + 1'b1;
		end else if (c >= CH_ZERO && c <= CH_NINE) begin
			acc = oct_val * 10 + c - CH_ZERO;
			if (oct_digs == 0 && c == CH_ZERO)
				oct_lz = 1'b1;
			oct_val = (acc > 256) ? OCTET_SAT : acc[8:0];
			if (oct_digs < DIG_SAT)
				oct_digs = oct_digs + 1'b1;
		end else begin
			fmt_err = 1'b1;
		end
		if (!fin)
			return 1'b0;
		end_octet();
		named = !name_off && name_pos == NAME_LEN;
		good = !fmt_err && dot_cnt == NEEDED_DOTS && len_cnt >= MIN_CHARS && len_cnt <= MAX_LEN;
		v.address_ok = named || good;
		v.matched_localhost = named;
		clear_scan();
		return 1'b1;
	endfunction

	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// returns at a falling edge with in_valid still high; the caller drives it in that step
	task automatic send_word(input logic [7:0] c, input logic fin);
		int gap;
		verdict_t v;
		gap = pick_gap(quiet_in);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		last_char <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (scan_char(c, fin, v))
			verdict_q.push_back(v);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_buf();
		int i;
		for (i = 0; i < str_len; i++)
			send_word(str_buf[i], i == str_len - 1);
		strings_sent++;
	endtask

	task automatic load_text(input logic [8*24-1:0] t);
		int n;
		int i;
		n = 24;
		while (n > 0 && t[8*(n-1) +: 8] == 8'h00)
			n--;
		for (i = 0; i < n; i++)
			str_buf[i] = t[8*(n-1-i) +: 8];
		str_len = n;
	endtask

	task automatic send_text(input logic [8*24-1:0] t);
		load_text(t);
		send_buf();
	endtask

	task automatic wait_for_verdicts();
		in_valid <= 1'b0;
		@(negedge clk);
		while (verdict_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic put_char(input logic [7:0] c);
		if (str_len < BUF_LEN) begin
			str_buf[str_len] = c;
			str_len++;
		end
	endtask

	task automatic put_decimal(input int v);
		if (v >= 100)
			put_char(8'(CH_ZERO + v / 100));
		if (v >= 10)
			put_char(8'(CH_ZERO + (v / 10) % 10));
		put_char(8'(CH_ZERO + v % 10));
	endtask

	task automatic gen_address();
		int n_oct;
		int k;
		int r;
		str_len = 0;
		r = $urandom_range(0, 99);
		n_oct = (r < 85) ? 4 : (r < 93) ? 3 : 5;
		for (k = 0; k < n_oct; k++) begin
			if (k > 0)
				put_char(CH_DOT);
			r = $urandom_range(0, 99);
			if (r < 78) begin
				case ($urandom_range(0, 3))
					0: put_decimal($urandom_range(0, 9));
					1: put_decimal($urandom_range(10, 99));
					2: put_decimal($urandom_range(100, 255));
					default: put_decimal(($urandom_range(0, 1) != 0) ? 255 : 0);
				endcase
			end else if (r < 84) begin
				put_char(CH_ZERO);
				put_decimal($urandom_range(0, 99));
			end else if (r < 90) begin
				put_decimal($urandom_range(256, 999));
			end else if (r >= 94) begin
				repeat ($urandom_range(4, 6))
					put_char(8'(CH_ZERO + $urandom_range(0, 9)));
			end
		end
		if ($urandom_range(0, 9) == 0)
			str_buf[$urandom_range(0, str_len - 1)] = 8'($urandom_range(0, 255));
	endtask

	task automatic gen_host_like();
		load_text("localhost");
		case ($urandom_range(0, 4))
			0: str_buf[$urandom_range(0, 8)] = 8'($urandom_range(0, 255));
			1: str_buf[$urandom_range(0, 8)] = 8'($urandom_range(8'h61, 8'h7a));
			2: str_len = $urandom_range(1, 8);
			3: put_char(8'($urandom_range(0, 255)));
			default: ;
		endcase
	endtask

	task automatic gen_noise();
		int n;
		int r;
		str_len = 0;
		n = $urandom_range(1, 20);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				put_char(8'(CH_ZERO + $urandom_range(0, 9)));
			else if (r < 70)
				put_char(CH_DOT);
			else
				put_char(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_directed_addresses();
		send_text("0.0.0.0");
		send_text("255.255.255.255");
		send_text("1.1.1.1");
		send_text("10.0.0.10");
		send_text("256.1.1.1");
		send_text("1.2.3.999");
		send_text("01.2.3.4");
		send_text("1.2.3.00");
		send_text("1.2.3");
		send_text("1.2.3.4.5");
		send_text(".1.2.3");
		send_text("1.2.3.");
		send_text("1..2.3");
		send_text("1234.1.1.1");
		send_text("100.100.100.1000");
		send_text("7");
	endtask

	task automatic test_localhost_names();
		send_text("localhost");
		send_text("localhos");
		send_text("localhostt");
		send_text("Localhost");
		send_text("l");
	endtask

	task automatic test_bad_bytes();
		load_text("1.2.3.4");
		str_buf[2] = 8'hff;
		send_buf();
		load_text("10.0.0.1");
		str_buf[0] = 8'h80;
		send_buf();
		send_text("1.2.3/4");
		send_text("1.2:3.4");
		send_word(8'h00, 1'b1);
		strings_sent++;
	endtask

	task automatic test_drain_pause();
		repeat (4) begin
			gen_address();
			send_buf();
			wait_for_verdicts();
		end
	endtask

	task automatic test_random_strings();
		int first;
		int r;
		first = chars_sent;
		while (chars_sent - first < RUN_ITEMS) begin
			if ($urandom_range(0, 19) == 0)
				quiet_in = !quiet_in;
			if ($urandom_range(0, 19) == 0)
				quiet_out = !quiet_out;
			r = $urandom_range(0, 99);
			if (r < 55)
				gen_address();
			else if (r < 70)
				gen_host_like();
			else
				gen_noise();
			send_buf();
		end
		quiet_in = 1'b0;
		quiet_out = 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_left == 0 && !quiet_out && $urandom_range(0, 99) < 30)
			stall_left = pick_gap(1'b0);
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_v.address_ok = address_ok;
			got_v.matched_localhost = matched_localhost;
			verdicts_seen++;
			ok_seen += int'(address_ok);
			host_seen += int'(matched_localhost);
			if (verdict_q.size() == 0) begin
				if (err_count < 10)
					$display("%0t: verdict with none pending: ok=%0b host=%0b",
						$realtime, address_ok, matched_localhost);
				err_count++;
			end else begin
				want_v = verdict_q.pop_front();
				if (want_v.address_ok !== got_v.address_ok ||
					want_v.matched_localhost !== got_v.matched_localhost) begin
					if (err_count < 10)
						$display("%0t: verdict %0d: expected ok=%0b host=%0b, got ok=%0b host=%0b",
							$realtime, verdicts_seen, want_v.address_ok,
							want_v.matched_localhost, got_v.address_ok,
							got_v.matched_localhost);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d verdicts pending", cycle_count,
				verdict_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		clear_scan();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_addresses();
		test_localhost_names();
		test_bad_bytes();
		test_drain_pause();
		test_random_strings();
		wait_for_verdicts();
		repeat (10) @(negedge clk);
		$display("Sent %0d characters in %0d strings; checked %0d verdicts", chars_sent,
			strings_sent, verdicts_seen);
		$display("Accepted %0d, localhost %0d, mismatches %0d", ok_seen, host_seen, err_count);
		if (err_count == 0 && verdict_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
